@@ rtl/frl_pkg.sv @@
// Shared types, constants and helpers for the flow rate limiter.
package frl_pkg;

  localparam int unsigned FLOW_ENTRIES_DEF = 256;
  localparam int unsigned IDX_W = 8;

  localparam logic [1:0] MODE_CHECK = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [1:0] REG_STRATEGY = 2'd0;
  localparam logic [1:0] REG_CAPACITY = 2'd1;
  localparam logic [1:0] REG_REFILL   = 2'd2;
  localparam logic [1:0] REG_WINDOW   = 2'd3;

  // Per-flow record kept in the entry memory.
  typedef struct packed {
    logic [15:0] tokens;
    logic [31:0] last_ms;
    logic [31:0] req_cnt;
    logic [31:0] ref_cnt;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic [1:0]  mode;
    logic        in_range;
    logic [IDX_W-1:0] idx;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic        granted;
    logic [15:0] remaining;
    logic [11:0] retry_after_s;
    logic [31:0] request_total;
    logic [31:0] blocked_total;
  } result_t;

  typedef struct packed {
    logic        strategy;
    logic [15:0] capacity;
    logic [15:0] refill;
    logic [11:0] window;
  } cfg_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

@@ rtl/flow_rate_limiter_unit.sv @@
// Top level of the per-flow token bucket and fixed-window policer.
// The back end handles one request at a time: it reads the flow entry, splits the
// elapsed time into whole seconds and leftover milliseconds by reciprocal
// multiplication, scales both parts by the refill rate, then writes the entry back
// and registers the result. A request taken by an idle back end passes through the
// read, multiply, divide and done states before its result is registered, and no
// new request starts until that result is taken. A waiting result holds the back
// end; the two-entry front queue then fills and drops s_tready. Flow indexes at or
// above FLOW_ENTRIES give all-zero results. No clearing pass: entry valid bits
// reset at once.
module flow_rate_limiter_unit #(
  parameter int unsigned FLOW_ENTRIES = frl_pkg::FLOW_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // mode[1:0], flow_index[9:2], now_ms[41:10]
  output logic        m_tvalid,
  input  logic        m_tready,
  // granted[0], remaining[16:1], retry_after_s[28:17], request_total[60:29],
  // blocked_total[92:61]
  output logic [95:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  frl_pkg::cfg_t    cfg;
  frl_pkg::req_t    qd;
  frl_pkg::result_t rd;
  logic             qv, qr;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strategy <= 1'b0;
      cfg.capacity <= 16'd20;
      cfg.refill   <= 16'd10;
      cfg.window   <= 12'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        frl_pkg::REG_STRATEGY: cfg.strategy <= cfg_data[0];
        frl_pkg::REG_CAPACITY: cfg.capacity <= cfg_data;
        frl_pkg::REG_REFILL:   cfg.refill   <= cfg_data;
        frl_pkg::REG_WINDOW:   cfg.window   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  frl_front #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_front (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .mode(s_tdata[1:0]), .flow_index(s_tdata[9:2]), .now_ms(s_tdata[41:10]),
    .q_valid(qv), .q_ready(qr), .q_data(qd)
  );

  frl_back #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(qv), .q_ready(qr), .q_data(qd),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(rd)
  );

  assign m_tdata = {3'd0, rd.blocked_total, rd.request_total, rd.retry_after_s,
                    rd.remaining, rd.granted};
endmodule

@@ rtl/frl_ram.sv @@
// Generic single-port-write, registered-read RAM.
module frl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/frl_front.sv @@
// Front end: accepts transactions, classifies them and queues them.
module frl_front #(
  parameter int unsigned FLOW_ENTRIES = frl_pkg::FLOW_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     mode,
  input  logic [7:0]     flow_index,
  input  logic [31:0]    now_ms,
  output logic           q_valid,
  input  logic           q_ready,
  output frl_pkg::req_t  q_data
);
  localparam int unsigned DEPTH = 2;

  frl_pkg::req_t slot [DEPTH];
  logic          wp, rp;
  logic [1:0]    cnt;
  logic          push, pop;

  assign in_ready = (cnt != 2'(DEPTH));
  assign q_valid  = (cnt != 2'd0);
  assign q_data   = slot[rp];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  // Classify and store the transaction.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp].mode     <= mode;
      slot[wp].in_range <= (32'(flow_index) < FLOW_ENTRIES);
      slot[wp].idx      <= flow_index[frl_pkg::IDX_W-1:0];
      slot[wp].now_ms   <= now_ms;
    end
  end
endmodule

@@ rtl/frl_back.sv @@
// Back end: entry lookup, policing arithmetic, write-back and result register.
module frl_back #(
  parameter int unsigned FLOW_ENTRIES = frl_pkg::FLOW_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  frl_pkg::cfg_t    cfg,
  input  logic             q_valid,
  output logic             q_ready,
  input  frl_pkg::req_t    q_data,
  output logic             out_valid,
  input  logic             out_ready,
  output frl_pkg::result_t out_data
);
  localparam int unsigned AW = (FLOW_ENTRIES > 256) ? 8 : $clog2(FLOW_ENTRIES);
  localparam int unsigned VN = 1 << AW;
  // Reciprocal of 1000 scaled by 2^38; the quotient is exact for any 32-bit dividend.
  localparam logic [28:0] DIV_MAGIC = 29'd274877907;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t          state;
  frl_pkg::req_t   req;
  frl_pkg::entry_t ent, rdata, wdata;
  logic            we;
  logic [AW-1:0]   raddr;
  logic [VN-1:0]   valid;
  logic            was_valid;
  logic [31:0]     elapsed;
  // Elapsed time split into whole seconds and leftover milliseconds.
  logic [60:0]     sec_prod;
  logic [31:0]     secs_q;
  logic [9:0]      ms_left;
  logic [38:0]     whole;
  logic [25:0]     frac;
  logic [54:0]     frac_prod;
  logic [39:0]     quo;

  // The entry address is held on the current request until it is written back.
  assign raddr = (state == S_IDLE) ? q_data.idx[AW-1:0] : req.idx[AW-1:0];

  frl_ram #(.WIDTH(frl_pkg::ENTRY_W), .DEPTH(VN)) u_ram (
    .clk(clk), .we(we), .waddr(req.idx[AW-1:0]), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign q_ready = (state == S_IDLE) && !out_valid;

  // Entry as seen after first touch.
  always_comb begin
    ent = rdata;
    if (!was_valid) begin
      ent.tokens  = cfg.capacity;
      ent.last_ms = req.now_ms;
      ent.req_cnt = 32'd0;
      ent.ref_cnt = 32'd0;
    end
    elapsed = req.now_ms - ent.last_ms;
  end

  // Whole seconds, leftover milliseconds and the refill of the leftover part.
  assign sec_prod  = 61'(elapsed) * 61'(DIV_MAGIC);
  assign ms_left   = 10'(elapsed - secs_q * 32'd1000);
  assign frac_prod = 55'(frac) * 55'(DIV_MAGIC);

  // Finishing arithmetic and write-back data.
  frl_pkg::result_t res;
  logic [47:0] lvl;
  logic [31:0] secs, cnt;
  always_comb begin
    res   = '0;
    wdata = ent;
    we    = 1'b0;
    lvl   = 48'(ent.tokens) + 48'(quo);
    secs  = secs_q;
    cnt   = ent.req_cnt;
    if (req.in_range && req.mode == frl_pkg::MODE_CHECK) begin
      we = 1'b1;
      if (!cfg.strategy) begin
        if (lvl > 48'(cfg.capacity)) lvl = 48'(cfg.capacity);
        wdata.last_ms = req.now_ms;
        if (lvl != 48'd0) begin
          lvl = lvl - 48'd1;
          wdata.req_cnt = frl_pkg::sat_inc(ent.req_cnt);
          res.granted = 1'b1;
          res.remaining = lvl[15:0];
        end else begin
          wdata.ref_cnt = frl_pkg::sat_inc(ent.ref_cnt);
          res.retry_after_s = (cfg.refill <= 16'd1) ? 12'd1 : 12'd0;
        end
        wdata.tokens = lvl[15:0];
      end else begin
        if (secs >= 32'(cfg.window)) begin
          cnt = 32'd0;
          wdata.last_ms = req.now_ms;
          secs = 32'd0;
        end
        if (cnt < 32'(cfg.capacity)) begin
          cnt = cnt + 32'd1;
          res.granted = 1'b1;
          res.remaining = 16'(32'(cfg.capacity) - cnt);
        end else begin
          wdata.ref_cnt = frl_pkg::sat_inc(ent.ref_cnt);
          res.retry_after_s = 12'(32'(cfg.window) - secs);
        end
        wdata.req_cnt = cnt;
      end
      res.request_total = wdata.req_cnt;
      res.blocked_total = wdata.ref_cnt;
    end else if (req.in_range && req.mode == frl_pkg::MODE_READ && was_valid) begin
      res.remaining = !cfg.strategy ? ent.tokens :
        ((ent.req_cnt >= 32'(cfg.capacity)) ? 16'd0 :
         16'(32'(cfg.capacity) - ent.req_cnt));
      res.request_total = ent.req_cnt;
      res.blocked_total = ent.ref_cnt;
    end
    if (state != S_DONE) we = 1'b0;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (q_valid && q_ready) begin
          req <= q_data;
          was_valid <= valid[q_data.idx[AW-1:0]] && q_data.in_range;
          state <= S_READ;
        end
        S_READ: begin
          secs_q <= 32'(sec_prod[60:38]);
          state <= S_MUL;
        end
        S_MUL: begin
          whole <= 39'(secs_q[22:0]) * 39'(cfg.refill);
          frac  <= 26'(ms_left) * 26'(cfg.refill);
          state <= S_DIV;
        end
        S_DIV: begin
          quo <= 40'(whole) + 40'(frac_prod[54:38]);
          state <= S_DONE;
        end
        S_DONE: begin
          out_data <= res;
          out_valid <= 1'b1;
          if (req.in_range && req.mode == frl_pkg::MODE_CHECK)
            valid[req.idx[AW-1:0]] <= 1'b1;
          if (req.in_range && req.mode == frl_pkg::MODE_CLEAR)
            valid[req.idx[AW-1:0]] <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/frl_checker.sv @@
// Port-level checks for the flow rate limiter, bound to the top level.
module frl_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata
);
  // A result held under back-pressure keeps its data.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  // A grant never carries a retry wait.
  a_grant: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[28:17] == 12'd0)
    else $error("granted with retry");
  // No result appears right after reset.
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result after reset");
  // The input is open right after reset.
  a_ready_rst: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");
endmodule

bind flow_rate_limiter_unit frl_port_checks u_chk (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
